>>> rtl/sla_pkg.sv
package sla_pkg;

  // Default line capacity; the store holds one character fewer
  localparam int unsigned LINE_CAPACITY_DEF = 64;

  // Character codes with special meaning
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  // Field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned TIMER_W    = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [TIMER_W-1:0] TIMER_MAX = 16'hFFFF;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BRIDGE_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOTICE_IVAL   = 1'd1;

  // Register reset values
  localparam logic                  ENABLE_RST = 1'b1;
  localparam logic [TIMER_W-1:0]    IVAL_RST   = 16'd1000;

  // Input beat kinds (tuser on the slave side)
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Result kinds (tuser on the master side)
  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_NOTICE = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NOTICE,
    ST_FETCH,
    ST_EMIT
  } sla_state_e;

  // One result beat handed to the output register
  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data;
    logic              last;
  } out_beat_t;

endpackage

>>> rtl/sla_line_mem.sv
module sla_line_mem #(
  parameter int unsigned DEPTH = 63,
  parameter int unsigned AW    = 6
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [sla_pkg::BYTE_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [sla_pkg::BYTE_W-1:0] rdata_o
);

  logic [sla_pkg::BYTE_W-1:0] mem_q [DEPTH];
  logic [sla_pkg::BYTE_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sla_out_reg.sv
module sla_out_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       ld_i,
  input  sla_pkg::out_beat_t         beat_i,
  output logic                       free_o,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [sla_pkg::BYTE_W-1:0] m_axis_tdata,  // [7:0] out_byte
  output logic                       m_axis_tuser,  // [0] result_kind
  output logic                       m_axis_tlast   // last_item
);

  logic               valid_q, valid_d;
  sla_pkg::out_beat_t beat_q;

  // Slot is free when empty or being drained this cycle
  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (m_axis_tready) begin
      valid_d = 1'b0;
    end
    if (ld_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      beat_q <= beat_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = beat_q.data;
  assign m_axis_tuser  = beat_q.kind;
  assign m_axis_tlast  = beat_q.last;

endmodule

>>> rtl/serial_line_assembler.sv
// Channel   | Dir | Handshake                   | Payload
// ----------+-----+-----------------------------+-------------------------------------
// s_axis    | in  | s_axis_tvalid_i/tready_o    | tuser: req_type, tdata: rx_byte
// m_axis    | out | m_axis_tvalid_o/tready_i    | tuser: result_kind, tdata: out_byte,
//           |     |                             | tlast: last_item
// cfg       | in  | cfg_we_i                    | cfg_idx_i, cfg_wdata_i
//
// Bytes and ticks are accepted only while idle. A newline ending a line runs
// through the accept, a fetch of the first character from the line memory, then
// one character per cycle while the output is free, each read issued as the
// previous beat is loaded. A truncation notice has its own state. Output
// back-pressure stalls the emit sequence beat for beat. Reset clears control
// state only; the line memory needs no clearing as only the current line is read.
module serial_line_assembler #(
  parameter int unsigned LINE_CAPACITY = sla_pkg::LINE_CAPACITY_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [sla_pkg::BYTE_W-1:0]     s_axis_tdata_i,  // [7:0] rx_byte
  input  logic                           s_axis_tuser_i,  // [0] req_type
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [sla_pkg::BYTE_W-1:0]     m_axis_tdata_o,  // [7:0] out_byte
  output logic                           m_axis_tuser_o,  // [0] result_kind
  output logic                           m_axis_tlast_o,  // last_item
  input  logic                           cfg_we_i,
  input  logic [sla_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sla_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned DEPTH = LINE_CAPACITY - 1;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW    = $clog2(LINE_CAPACITY);

  sla_pkg::sla_state_e state_q, state_d;

  logic [LW-1:0]                   len_q, len_d;
  logic [AW-1:0]                   idx_q, idx_d;
  logic                            discard_q, discard_d;
  logic [sla_pkg::TIMER_W-1:0]     timer_q, timer_d;
  logic                            enable_q, enable_d;
  logic [sla_pkg::TIMER_W-1:0]     ival_q, ival_d;

  logic                            mem_we;
  logic                            mem_re;
  logic [AW-1:0]                   mem_raddr;
  logic [sla_pkg::BYTE_W-1:0]      mem_rdata;

  logic                            out_ld;
  logic                            out_free;
  sla_pkg::out_beat_t              out_beat;
  logic                            last_char;

  // Line memory; writes happen only while idle, so no read overlaps a write
  sla_line_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (len_q[AW-1:0]),
    .wdata_i (s_axis_tdata_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Result register towards the master side
  sla_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ld_i          (out_ld),
    .beat_i        (out_beat),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid_o),
    .m_axis_tready (m_axis_tready_i),
    .m_axis_tdata  (m_axis_tdata_o),
    .m_axis_tuser  (m_axis_tuser_o),
    .m_axis_tlast  (m_axis_tlast_o)
  );

  assign last_char = ((LW'(idx_q) + LW'(1)) == len_q);

  // Next state and datapath control
  always_comb begin
    state_d         = state_q;
    len_d           = len_q;
    idx_d           = idx_q;
    discard_d       = discard_q;
    timer_d         = timer_q;
    enable_d        = enable_q;
    ival_d          = ival_q;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_raddr       = idx_q;
    out_ld          = 1'b0;
    out_beat        = '{kind: sla_pkg::KIND_CHAR, data: mem_rdata, last: last_char};
    s_axis_tready_o = 1'b0;

    case (state_q)
      sla_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i == sla_pkg::REQ_TICK) begin
            // saturating millisecond count
            if (timer_q != sla_pkg::TIMER_MAX) begin
              timer_d = timer_q + sla_pkg::TIMER_W'(1);
            end
          end else if (enable_q) begin
            if (discard_q) begin
              if (s_axis_tdata_i == sla_pkg::CHAR_LF) begin
                discard_d = 1'b0;
                len_d     = '0;
              end
            end else if (s_axis_tdata_i == sla_pkg::CHAR_CR) begin
              // dropped
            end else if (s_axis_tdata_i == sla_pkg::CHAR_LF) begin
              if (len_q != '0) begin
                idx_d   = '0;
                state_d = sla_pkg::ST_FETCH;
              end
            end else if (len_q < LW'(DEPTH)) begin
              mem_we = 1'b1;
              len_d  = len_q + LW'(1);
            end else begin
              // overflow: drop the line, notice if the interval has passed
              len_d     = '0;
              discard_d = 1'b1;
              if (timer_q >= ival_q) begin
                timer_d = '0;
                state_d = sla_pkg::ST_NOTICE;
              end
            end
          end
        end
      end

      sla_pkg::ST_NOTICE: begin
        if (out_free) begin
          out_ld   = 1'b1;
          out_beat = '{kind: sla_pkg::KIND_NOTICE, data: '0, last: 1'b1};
          state_d  = sla_pkg::ST_IDLE;
        end
      end

      sla_pkg::ST_FETCH: begin
        // first character read
        mem_re  = 1'b1;
        state_d = sla_pkg::ST_EMIT;
      end

      sla_pkg::ST_EMIT: begin
        // read data belongs to idx_q and holds across stalls
        if (out_free) begin
          out_ld = 1'b1;
          if (last_char) begin
            len_d   = '0;
            state_d = sla_pkg::ST_IDLE;
          end else begin
            idx_d     = idx_q + AW'(1);
            mem_re    = 1'b1;
            mem_raddr = idx_q + AW'(1);
          end
        end
      end

      default: begin
        state_d = sla_pkg::ST_IDLE;
      end
    endcase

    // Register writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        sla_pkg::REG_BRIDGE_ENABLE: begin
          enable_d  = cfg_wdata_i[0];
          len_d     = '0;
          discard_d = 1'b0;
        end
        sla_pkg::REG_NOTICE_IVAL: begin
          ival_d = cfg_wdata_i[sla_pkg::TIMER_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Control and register state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sla_pkg::ST_IDLE;
      len_q     <= '0;
      idx_q     <= '0;
      discard_q <= 1'b0;
      timer_q   <= '0;
      enable_q  <= sla_pkg::ENABLE_RST;
      ival_q    <= sla_pkg::IVAL_RST;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      idx_q     <= idx_d;
      discard_q <= discard_d;
      timer_q   <= timer_d;
      enable_q  <= enable_d;
      ival_q    <= ival_d;
    end
  end

endmodule

>>> test/serial_line_assembler_tb.sv
module serial_line_assembler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sla_pkg::*;

  localparam int unsigned STORE_DEPTH  = LINE_CAPACITY_DEF - 1;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned PHASE_ITEMS  = 55;

  // One input beat: kind of request and the received character
  typedef struct packed {
    logic              req_type;
    logic [BYTE_W-1:0] rx_byte;
  } rx_beat_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [BYTE_W-1:0]     s_axis_tdata_i  = '0;
  logic                  s_axis_tuser_i  = REQ_BYTE;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [BYTE_W-1:0]     m_axis_tdata_o;
  logic                  m_axis_tuser_o;
  logic                  m_axis_tlast_o;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i     = '0;

  serial_line_assembler u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // Stimulus and scoreboard storage
  rx_beat_t    rx_pending_q[$];
  out_beat_t   line_expect_q[$];
  int unsigned queued_beats = 0;

  // Idling knobs, percent of cycles
  int unsigned snd_idle_pct  = 0;
  int unsigned rcv_stall_pct = 0;

  // Statistics
  int unsigned n_errors  = 0;
  int unsigned n_beats   = 0;
  int unsigned n_ticks   = 0;
  int unsigned n_results = 0;
  int unsigned n_lines   = 0;
  int unsigned n_notices = 0;
  int unsigned cycle_cnt = 0;

  // Line framer prediction state
  logic [BYTE_W-1:0]  lm_store [STORE_DEPTH];
  int unsigned        lm_len;
  logic               lm_discard;
  logic [TIMER_W-1:0] lm_timer;
  logic               lm_enable;
  logic [TIMER_W-1:0] lm_ival;

  // Predict the beats caused by one accepted input beat
  task automatic frame_rx_beat(input logic req, input logic [BYTE_W-1:0] c);
    out_beat_t b;
    if (req == REQ_TICK) begin
      if (lm_timer != TIMER_MAX) lm_timer++;
    end else if (!lm_enable) begin
      // disabled: byte dropped
    end else if (lm_discard) begin
      if (c == CHAR_LF) begin
        lm_discard = 1'b0;
        lm_len     = 0;
      end
    end else if (c == CHAR_CR) begin
      // carriage return dropped
    end else if (c == CHAR_LF) begin
      for (int unsigned i = 0; i < lm_len; i++) begin
        b.kind = KIND_CHAR;
        b.data = lm_store[i];
        b.last = (i + 1 == lm_len);
        line_expect_q.push_back(b);
      end
      lm_len = 0;
    end else if (lm_len < STORE_DEPTH) begin
      lm_store[lm_len] = c;
      lm_len++;
    end else begin
      // overflow: drop line, enter discard, maybe a notice
      lm_len     = 0;
      lm_discard = 1'b1;
      if (lm_timer >= lm_ival) begin
        lm_timer = '0;
        b.kind   = KIND_NOTICE;
        b.data   = '0;
        b.last   = 1'b1;
        line_expect_q.push_back(b);
      end
    end
  endtask

  // Clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_cnt);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Driver: predict on accept, then load the next beat or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        frame_rx_beat(s_axis_tuser_i, s_axis_tdata_i);
        n_beats++;
        if (s_axis_tuser_i == REQ_TICK) n_ticks++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (rx_pending_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= rx_pending_q[0].req_type;
          s_axis_tdata_i  <= rx_pending_q[0].rx_byte;
          void'(rx_pending_q.pop_front());
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    out_beat_t e;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        n_results++;
        if (m_axis_tuser_o == KIND_NOTICE) n_notices++;
        else if (m_axis_tlast_o) n_lines++;
        if (line_expect_q.size() == 0) begin
          $error("unexpected result beat: kind %0d byte %02h last %0d",
                 m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
          n_errors++;
        end else begin
          e = line_expect_q.pop_front();
          if (m_axis_tuser_o !== e.kind) begin
            $error("result_kind: expected %0d, got %0d", e.kind, m_axis_tuser_o);
            n_errors++;
          end
          if (m_axis_tdata_o !== e.data) begin
            $error("out_byte: expected %02h, got %02h", e.data, m_axis_tdata_o);
            n_errors++;
          end
          if (m_axis_tlast_o !== e.last) begin
            $error("last_item: expected %0d, got %0d", e.last, m_axis_tlast_o);
            n_errors++;
          end
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  task automatic push_beat(input logic req, input logic [BYTE_W-1:0] c);
    rx_beat_t b;
    b.req_type = req;
    b.rx_byte  = c;
    rx_pending_q.push_back(b);
    queued_beats++;
  endtask

  function automatic logic [BYTE_W-1:0] plain_char();
    logic [BYTE_W-1:0] c;
    do c = BYTE_W'($urandom_range(255));
    while (c == CHAR_LF || c == CHAR_CR);
    return c;
  endfunction

  // Text line of len characters, the odd CR mixed in, closed by LF
  task automatic push_line(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(7) == 0) push_beat(REQ_BYTE, CHAR_CR);
      push_beat(REQ_BYTE, plain_char());
    end
    push_beat(REQ_BYTE, CHAR_LF);
  endtask

  // Fill the store, then overrun it by extra bytes
  task automatic push_overflow(input int unsigned extra, input bit close);
    for (int unsigned i = 0; i < STORE_DEPTH + extra; i++) push_beat(REQ_BYTE, plain_char());
    if (close) push_beat(REQ_BYTE, CHAR_LF);
  endtask

  // Sender stops; wait for every result and the block to settle
  task automatic wait_idle();
    do @(posedge clk_i);
    while (rx_pending_q.size() > 0 || s_axis_tvalid_i || line_expect_q.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == REG_BRIDGE_ENABLE) begin
      lm_enable  = val[0];
      lm_len     = 0;
      lm_discard = 1'b0;
    end else if (idx == REG_NOTICE_IVAL) begin
      lm_ival = val;
    end
  endtask

  // Mostly well-formed lines with random content, some overruns, ticks and noise
  task automatic fill_random(input int unsigned n);
    int unsigned base;
    int unsigned sel;
    base = queued_beats;
    while (queued_beats - base < n) begin
      sel = $urandom_range(99);
      if (sel < 60) begin
        sel = $urandom_range(99);
        if (sel < 80) push_line($urandom_range(8));
        else if (sel < 94) push_line($urandom_range(62, 9));
        else push_line(STORE_DEPTH);
      end else if (sel < 64) begin
        push_overflow($urandom_range(4, 1), $urandom_range(4) != 0);
      end else if (sel < 82) begin
        repeat ($urandom_range(12, 1)) push_beat(REQ_TICK, BYTE_W'($urandom_range(255)));
      end else begin
        push_beat($urandom_range(3) == 0 ? REQ_TICK : REQ_BYTE, BYTE_W'($urandom_range(255)));
      end
    end
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input logic en, input logic [TIMER_W-1:0] ival,
                           input int unsigned n);
    wait_idle();
    write_reg(REG_BRIDGE_ENABLE, CFG_DATA_W'(en));
    write_reg(REG_NOTICE_IVAL, ival);
    snd_idle_pct  = idle;
    rcv_stall_pct = stall;
    fill_random(n);
  endtask

  initial begin
    lm_enable  = ENABLE_RST;
    lm_ival    = IVAL_RST;
    lm_len     = 0;
    lm_discard = 1'b0;
    lm_timer   = '0;
    foreach (lm_store[i]) lm_store[i] = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: byte extremes, null byte, CR dropped, empty lines, ticks
    push_beat(REQ_BYTE, 8'h00);
    push_beat(REQ_BYTE, 8'hFF);
    push_beat(REQ_BYTE, CHAR_CR);
    push_beat(REQ_BYTE, 8'h7E);
    push_beat(REQ_BYTE, CHAR_LF);
    push_beat(REQ_BYTE, CHAR_LF);
    push_beat(REQ_BYTE, CHAR_CR);
    push_beat(REQ_BYTE, CHAR_LF);
    push_beat(REQ_TICK, 8'hFF);
    push_beat(REQ_TICK, 8'h00);
    // overrun with the timer below the reset interval: no notice
    push_overflow(1, 1'b1);

    // Disabled: bytes ignored, ticks still counted
    wait_idle();
    write_reg(REG_BRIDGE_ENABLE, '0);
    push_beat(REQ_BYTE, 8'h41);
    push_beat(REQ_TICK, 8'h00);
    push_beat(REQ_BYTE, CHAR_LF);

    // Full line, then overrun with zero interval, discard until newline
    wait_idle();
    write_reg(REG_BRIDGE_ENABLE, CFG_DATA_W'(1));
    write_reg(REG_NOTICE_IVAL, '0);
    push_line(STORE_DEPTH);
    push_overflow(1, 1'b0);
    push_beat(REQ_BYTE, 8'h42);
    push_beat(REQ_BYTE, CHAR_CR);
    push_beat(REQ_BYTE, CHAR_LF);
    push_beat(REQ_BYTE, 8'h43);
    push_beat(REQ_BYTE, CHAR_LF);

    // Random phases across idling patterns and interval settings
    run_phase(0, 0, 1'b1, '0, PHASE_ITEMS);
    run_phase(76, 0, 1'b1, 16'd5, PHASE_ITEMS);
    run_phase(0, 76, 1'b1, TIMER_MAX, PHASE_ITEMS);
    run_phase(30, 30, 1'b1, 16'd20, PHASE_ITEMS);
    run_phase(30, 30, 1'b0, TIMER_W'($urandom_range(65535)), 40);

    wait_idle();
    $display("Covered %0d input beats (%0d ticks) and %0d result beats", n_beats, n_ticks,
             n_results);
    $display("  %0d lines framed, %0d truncation notices", n_lines, n_notices);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/sla_pkg.sv
rtl/sla_line_mem.sv
rtl/sla_out_reg.sv
rtl/serial_line_assembler.sv
test/serial_line_assembler_tb.sv
